@@ hw/rtl/assert_macros.svh @@
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence a fixed number of cycles after the antecedent
`define ASSERT_AFTER(label, clk, rst_n, ante, n, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/vdec_pkg.sv @@
package vdec_pkg;

    localparam int NUM_SYM    = 8;
    localparam int SYM_W      = 3;
    localparam int CW_W       = NUM_SYM * SYM_W;
    localparam int NUM_ST     = 4;
    localparam int MET_W      = 5;
    localparam int BYTE_W     = 8;
    localparam int MAX_METRIC = 24;

    // trellis stages after the merged first two
    localparam int NUM_ACS = NUM_SYM - 2;
    // head + acs stages + final select
    localparam int LATENCY = NUM_ACS + 2;

    // branch codeword for candidate k = 2*state + (pred >> 1)
    localparam logic [7:0][SYM_W-1:0] BRANCH = {
        3'd1, 3'd2, 3'd4, 3'd7, 3'd6, 3'd5, 3'd3, 3'd0
    };

    typedef logic [MET_W-1:0]  metric_t;
    typedef logic [BYTE_W-1:0] surv_t;

    typedef struct packed {
        logic [CW_W-1:0]          cw;
        metric_t [NUM_ST-1:0]     metric;
        surv_t [NUM_ST-1:0]       surv;
    } trellis_t;

    // received symbol has its msb at the lowest codeword bit
    function automatic logic [SYM_W-1:0] rev_sym(input logic [SYM_W-1:0] raw);
        rev_sym = {raw[0], raw[1], raw[2]};
    endfunction

    // hamming distance between symbol and branch codeword
    function automatic logic [1:0] branch_dist(input logic [SYM_W-1:0] sym,
                                               input logic [SYM_W-1:0] code);
        logic [SYM_W-1:0] d;
        d = sym ^ code;
        branch_dist = {1'b0, d[0]} + {1'b0, d[1]} + {1'b0, d[2]};
    endfunction

endpackage

@@ hw/rtl/viterbi_decode_r13_k3_byte.sv @@
// Hard-decision Viterbi decoder, rate 1/3, K=3, one 24-bit codeword per byte.
// A codeword is transferred when start is high and busy is low; busy is high only
// during reset and the first clock after it, so a new codeword can be transferred
// every cycle. Each codeword yields one result exactly 8 cycles later: decoded_byte
// and path_metric are valid for the single cycle in which done is high, and must be
// taken then. The latency is set by the trellis pipeline: one stage for the first
// two symbols, one add-compare-select stage for each of the remaining six symbols,
// and one stage for the final minimum search.
`include "assert_macros.svh"

module viterbi_decode_r13_k3_byte
    import vdec_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [CW_W-1:0]   codeword,
    output logic              done,
    output logic [BYTE_W-1:0] decoded_byte,
    output logic [MET_W-1:0]  path_metric
);

    logic     busy_reg;
    logic     xfer;
    logic     st_valid [NUM_ACS + 1];
    trellis_t st_data  [NUM_ACS + 1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b1;
        else
            busy_reg <= 1'b0;
    end

    assign busy = busy_reg;
    assign xfer = start && !busy_reg;

    vdec_head u_head (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (xfer),
        .codeword  (codeword),
        .out_valid (st_valid[0]),
        .out_data  (st_data[0])
    );

    // stage g decodes symbol g + 1
    for (genvar g = 1; g <= NUM_ACS; g++)
    begin : g_acs
        vdec_acs u_acs (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (st_valid[g - 1]),
            .sym       (rev_sym(st_data[g - 1].cw[SYM_W * (g + 1) +: SYM_W])),
            .in_data   (st_data[g - 1]),
            .out_valid (st_valid[g]),
            .out_data  (st_data[g])
        );
    end

    vdec_sel u_sel (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (st_valid[NUM_ACS]),
        .in_data      (st_data[NUM_ACS]),
        .done         (done),
        .decoded_byte (decoded_byte),
        .path_metric  (path_metric)
    );

    `ASSERT_AFTER(a_latency, clk, rst_n, xfer, LATENCY, done, "transfer did not give a result")
    `ASSERT_IMPLIES(a_no_spurious, clk, rst_n, done, $past(xfer, LATENCY), "result without transfer")
    `ASSERT_IMPLIES(a_metric_range, clk, rst_n, done, path_metric <= metric_t'(MAX_METRIC), "metric too large")
    `ASSERT_IMPLIES(a_zero_word, clk, rst_n, done && $past(codeword, LATENCY) == '0, decoded_byte == '0 && path_metric == '0, "zero codeword misdecoded")

endmodule

@@ hw/rtl/vdec_head.sv @@
module vdec_head
    import vdec_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [CW_W-1:0] codeword,
    output logic            out_valid,
    output trellis_t        out_data
);

    logic               valid_reg;
    trellis_t           data_reg;
    trellis_t           data_next;
    logic [SYM_W-1:0]   sym0;
    logic [SYM_W-1:0]   sym1;
    metric_t            m0 [NUM_ST];

    assign sym0 = rev_sym(codeword[0 +: SYM_W]);
    assign sym1 = rev_sym(codeword[SYM_W +: SYM_W]);

    // first symbol: only states 0 and 1 have a reachable path, 2 and 3 start at zero
    assign m0[0] = metric_t'(branch_dist(sym0, BRANCH[0]));
    assign m0[1] = metric_t'(branch_dist(sym0, BRANCH[2]));
    assign m0[2] = '0;
    assign m0[3] = '0;

    // second symbol: odd candidates are unreachable, so the even one always wins
    always_comb
    begin
        data_next.cw = codeword;
        for (int j = 0; j < NUM_ST; j++)
        begin
            data_next.metric[j] = metric_t'(branch_dist(sym1, BRANCH[2 * j]))
                                  + m0[j / 2];
            data_next.surv[j]   = surv_t'(j);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ hw/rtl/vdec_acs.sv @@
module vdec_acs
    import vdec_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [SYM_W-1:0] sym,
    input  trellis_t         in_data,
    output logic             out_valid,
    output trellis_t         out_data
);

    logic     valid_reg;
    trellis_t data_reg;
    trellis_t data_next;
    metric_t  nmet  [NUM_ST];
    surv_t    nsurv [NUM_ST];

    for (genvar j = 0; j < NUM_ST; j++)
    begin : g_state
        localparam int PE = j / 2;
        localparam int PO = j / 2 + 2;

        metric_t cand_e;
        metric_t cand_o;
        logic    pick;
        surv_t   prev;

        assign cand_e = metric_t'(branch_dist(sym, BRANCH[2 * j])) + in_data.metric[PE];
        assign cand_o = metric_t'(branch_dist(sym, BRANCH[2 * j + 1])) + in_data.metric[PO];
        // ties go to the even predecessor
        assign pick     = (cand_o < cand_e);
        assign prev     = pick ? in_data.surv[PO] : in_data.surv[PE];
        assign nmet[j]  = pick ? cand_o : cand_e;
        assign nsurv[j] = {prev[BYTE_W-2:0], 1'(j % 2)};
    end

    always_comb
    begin
        data_next.cw = in_data.cw;
        for (int j = 0; j < NUM_ST; j++)
        begin
            data_next.metric[j] = nmet[j];
            data_next.surv[j]   = nsurv[j];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ hw/rtl/vdec_sel.sv @@
module vdec_sel
    import vdec_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  trellis_t          in_data,
    output logic              done,
    output logic [BYTE_W-1:0] decoded_byte,
    output logic [MET_W-1:0]  path_metric
);

    logic              done_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic [BYTE_W-1:0] byte_next;
    metric_t           metric_reg;
    metric_t           metric_next;
    logic [1:0]        a_idx;
    logic [1:0]        b_idx;
    logic [1:0]        best;
    metric_t           a_met;
    metric_t           b_met;
    surv_t             win;

    // pairwise minimum, lower state wins on ties at both levels
    always_comb
    begin
        a_idx = (in_data.metric[1] < in_data.metric[0]) ? 2'd1 : 2'd0;
        b_idx = (in_data.metric[3] < in_data.metric[2]) ? 2'd3 : 2'd2;
        a_met = in_data.metric[a_idx];
        b_met = in_data.metric[b_idx];
        best  = (b_met < a_met) ? b_idx : a_idx;
        metric_next = (b_met < a_met) ? b_met : a_met;
        win = in_data.surv[best];
        // survivor holds the oldest bit at the top
        for (int k = 0; k < BYTE_W; k++)
            byte_next[k] = win[BYTE_W - 1 - k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            byte_reg   <= byte_next;
            metric_reg <= metric_next;
        end
    end

    assign done         = done_reg;
    assign decoded_byte = byte_reg;
    assign path_metric  = metric_reg;

endmodule
